// ===== sv/sst_pkg.sv =====
// sst_pkg: types and constants for the sorted set table.
// Shared by sst_cell and sorted_set_table; depends on nothing.
package sst_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VAL_W        = 31;
	localparam int MODE_W       = 2;
	localparam int STATUS_W     = 3;
	localparam int OUT_CNT_W    = 7;

	localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEL = 2'd1;

	localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [VAL_W-1:0]  value;
	} cmd_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_CNT_W-1:0] entry_count;
		logic [VAL_W-1:0]     third_from_end;
		logic                 third_valid;
	} rsp_word_t;

	// update broadcast to every cell in the execute cycle
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [VAL_W-1:0] key;
	} upd_t;

	// what a cell hands to its right-hand neighbour
	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic             lt;
	} link_t;

endpackage

// ===== sv/sorted_set_table.sv =====
// sorted_set_table: top level; a row of sst_cell slots holding a sorted set.
// Uses sst_pkg and sst_cell.
//
// Usage:
//   Command word (cmd) is taken at a rising edge where start is high and busy
//   is low. mode selects add, delete or membership query (code three also
//   queries). The clock edge of acceptance latches compare flags in every
//   slot against the key; the next cycle resolves hit and full, then inserts
//   or deletes in one step by having each slot take its left or right
//   neighbour's value.
//   One response word (rsp) follows per command, marked by done for exactly
//   one cycle; done is registered from busy, which is registered from the
//   accept; the receiver cannot stall it. busy is high for one cycle after
//   each accept, so no new command is taken until the compare cycle and the
//   shift cycle of the cell row are through.
//   rsp carries status, the count after the command and the third-largest
//   value (zero with third_valid low when fewer than three are held).
//   Reset empties the set; slot contents are left as they are and are never
//   read beyond the count.
module sorted_set_table #(
	parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sst_pkg::cmd_word_t  cmd,
	output logic                done,
	output sst_pkg::rsp_word_t  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                            busy_q;
	logic                            done_q;
	logic [CW-1:0]                   count_q;
	logic [sst_pkg::STATUS_W-1:0]    status_q;
	logic [sst_pkg::MODE_W-1:0]      mode_s1;
	logic [sst_pkg::VAL_W-1:0]       key_s1;

	logic                            accept;
	logic                            hit;
	logic                            full;
	sst_pkg::upd_t                   upd;
	logic [sst_pkg::STATUS_W-1:0]    status_d;
	logic [CW-1:0]                   count_d;
	logic                            third_ok;
	logic [sst_pkg::VAL_W-1:0]       third_or;

	sst_pkg::link_t                  link_w [CAPACITY];
	logic [CAPACITY-1:0]             eq_w;
	logic [sst_pkg::VAL_W-1:0]       tap_w  [CAPACITY];

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			sst_pkg::link_t           left_in;
			logic [sst_pkg::VAL_W-1:0] right_in;

			if (gi == 0) begin : g_head
				assign left_in.val = '0;
				assign left_in.lt  = 1'b1;
			end else begin : g_body
				assign left_in = link_w[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_tail
				assign right_in = link_w[gi].val;
			end else begin : g_mid
				assign right_in = link_w[gi+1].val;
			end

			sst_cell #(
				.IDX (gi),
				.CW  (CW)
			) u_cell (
				.clk       (clk),
				.capture   (accept),
				.key       (cmd.value),
				.count     (count_q),
				.upd       (upd),
				.left      (left_in),
				.right_val (right_in),
				.link      (link_w[gi]),
				.eq        (eq_w[gi]),
				.tap       (tap_w[gi])
			);
		end
	endgenerate

	// values are distinct and sorted, so any equal slot is the hit
	assign hit  = |eq_w;
	assign full = count_q >= CW'(CAPACITY);

	always_comb begin
		upd.key  = key_s1;
		upd.ins  = 1'b0;
		upd.del  = 1'b0;
		count_d  = count_q;
		status_d = hit ? sst_pkg::ST_FOUND : sst_pkg::ST_NOTFOUND;
		case (mode_s1)
			sst_pkg::MODE_ADD: begin
				if (hit) begin
					status_d = sst_pkg::ST_PRESENT;
				end else if (full) begin
					status_d = sst_pkg::ST_FULL;
				end else begin
					status_d = sst_pkg::ST_ADDED;
					upd.ins  = busy_q;
					count_d  = count_q + CW'(1);
				end
			end
			sst_pkg::MODE_DEL: begin
				if (hit) begin
					status_d = sst_pkg::ST_DELETED;
					upd.del  = busy_q;
					count_d  = count_q - CW'(1);
				end else begin
					status_d = sst_pkg::ST_ABSENT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= cmd.mode;
			key_s1  <= cmd.value;
		end
		if (busy_q) begin
			status_q <= status_d;
		end
	end

	always_comb begin
		third_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			third_or = third_or | tap_w[i];
		end
	end

	assign third_ok = count_q >= CW'(3);

	assign done               = done_q;
	assign rsp.status         = status_q;
	assign rsp.entry_count    = sst_pkg::OUT_CNT_W'(count_q);
	assign rsp.third_from_end = third_ok ? third_or : '0;
	assign rsp.third_valid    = third_ok;

endmodule

// ===== sv/sst_cell.sv =====
// sst_cell: one slot of the sorted row; holds a value, compares it with the key
// and shifts left or right on delete or insert. Uses sst_pkg.
module sst_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic                    clk,
	input  logic                    capture,
	input  logic [sst_pkg::VAL_W-1:0] key,
	input  logic [CW-1:0]           count,
	input  sst_pkg::upd_t           upd,
	input  sst_pkg::link_t          left,
	input  logic [sst_pkg::VAL_W-1:0] right_val,
	output sst_pkg::link_t          link,
	output logic                    eq,
	output logic [sst_pkg::VAL_W-1:0] tap
);

	logic [sst_pkg::VAL_W-1:0] val_q;
	logic                      lt_q;
	logic                      eq_q;
	logic                      occ;
	logic                      sel;

	assign occ = CW'(IDX) < count;
	// this slot is third from the end when count == IDX + 3
	assign sel = {1'b0, count} == (CW+1)'(IDX + 3);

	always_ff @(posedge clk) begin
		if (capture) begin
			lt_q <= occ && (val_q < key);
			eq_q <= occ && (val_q == key);
		end
	end

	always_ff @(posedge clk) begin
		if (upd.ins && !lt_q) begin
			val_q <= left.lt ? upd.key : left.val;
		end else if (upd.del && !lt_q) begin
			val_q <= right_val;
		end
	end

	assign link.val = val_q;
	assign link.lt  = lt_q;
	assign eq       = eq_q;
	assign tap      = sel ? val_q : '0;

endmodule

// ===== bench/tb_sorted_set_table.sv =====
// tb_sorted_set_table: self-checking bench for the sorted set table.
// A directed table, then random add/delete/query traffic, checked word by word
// against typed rows or an in-bench set model. Depends on sst_pkg and sorted_set_table.
`timescale 1ns / 100ps

module tb_sorted_set_table;

	localparam int                         CAP        = sst_pkg::CAPACITY_DEF;
	localparam logic [sst_pkg::MODE_W-1:0] MODE_QRY   = 2'd2;
	localparam logic [sst_pkg::MODE_W-1:0] MODE_QRY3  = 2'd3;
	localparam logic [sst_pkg::VAL_W-1:0]  VAL_MAX    = {sst_pkg::VAL_W{1'b1}};
	localparam int                         RAND_ITEMS = 1530;
	localparam int                         POOL_N     = 80;
	localparam int                         STALL_MAX  = 2000;
	localparam int                         SHOW_MAX   = 10;

	typedef struct {
		logic [sst_pkg::MODE_W-1:0] mode;
		logic [sst_pkg::VAL_W-1:0]  value;
		bit                         typed;
		sst_pkg::rsp_word_t         rsp;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	sst_pkg::cmd_word_t  cmd;
	logic                done;
	sst_pkg::rsp_word_t  rsp;

	// typed expectation travelling with the word on cmd
	bit                  cur_typed;
	sst_pkg::rsp_word_t  cur_rsp;

	logic [sst_pkg::VAL_W-1:0] held_vals [CAP];
	int                        held_cnt;
	sst_pkg::rsp_word_t        pending_rsp [$];
	dir_row_t                  dir_rows [$];
	logic [sst_pkg::VAL_W-1:0] val_pool [POOL_N];
	int                        mismatch_cnt;
	int                        stall_cycles;

	sorted_set_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	always #10 clk = ~clk;

	// Applies one word to the model set and returns the response it gives.
	function automatic sst_pkg::rsp_word_t set_update(sst_pkg::cmd_word_t c);
		sst_pkg::rsp_word_t r;
		int                 pos;
		bit                 hit;
		pos = 0;
		while (pos < held_cnt && held_vals[pos] < c.value)
			pos++;
		hit = (pos < held_cnt) && (held_vals[pos] == c.value);
		if (c.mode == sst_pkg::MODE_ADD) begin
			if (hit) begin
				r.status = sst_pkg::ST_PRESENT;
			end else if (held_cnt >= CAP) begin
				r.status = sst_pkg::ST_FULL;
			end else begin
				for (int k = held_cnt; k > pos; k--)
					held_vals[k] = held_vals[k-1];
				held_vals[pos] = c.value;
				held_cnt++;
				r.status = sst_pkg::ST_ADDED;
			end
		end else if (c.mode == sst_pkg::MODE_DEL) begin
			if (hit) begin
				for (int k = pos; k + 1 < held_cnt; k++)
					held_vals[k] = held_vals[k+1];
				held_cnt--;
				r.status = sst_pkg::ST_DELETED;
			end else begin
				r.status = sst_pkg::ST_ABSENT;
			end
		end else begin
			r.status = hit ? sst_pkg::ST_FOUND : sst_pkg::ST_NOTFOUND;
		end
		r.entry_count = held_cnt[sst_pkg::OUT_CNT_W-1:0];
		if (held_cnt >= 3) begin
			r.third_from_end = held_vals[held_cnt-3];
			r.third_valid    = 1'b1;
		end else begin
			r.third_from_end = '0;
			r.third_valid    = 1'b0;
		end
		return r;
	endfunction

	function automatic void add_row(logic [sst_pkg::MODE_W-1:0] m,
	                                logic [sst_pkg::VAL_W-1:0] v, bit t,
	                                logic [sst_pkg::STATUS_W-1:0] st, int n,
	                                logic [sst_pkg::VAL_W-1:0] third, logic tv);
		dir_row_t d;
		d.mode                 = m;
		d.value                = v;
		d.typed                = t;
		d.rsp.status           = st;
		d.rsp.entry_count      = n[sst_pkg::OUT_CNT_W-1:0];
		d.rsp.third_from_end   = third;
		d.rsp.third_valid      = tv;
		dir_rows.push_back(d);
	endfunction

	// Presents one word from the falling edge and holds it until taken.
	task automatic send_word(logic [sst_pkg::MODE_W-1:0] m, logic [sst_pkg::VAL_W-1:0] v,
	                         bit t, sst_pkg::rsp_word_t r, bit may_idle);
		if (may_idle && $urandom_range(99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start      <= 1'b1;
		cmd.mode   <= m;
		cmd.value  <= v;
		cur_typed  <= t;
		cur_rsp    <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Monitor: results are checked before the word taken at the same edge
	// is added, as a result always belongs to an earlier word.
	always @(posedge clk) begin
		sst_pkg::rsp_word_t want;
		sst_pkg::rsp_word_t got;
		if (arst_n) begin
			if (done || (start && !busy))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (done) begin
				got = rsp;
				if (pending_rsp.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= SHOW_MAX)
						$display("unexpected result word: status %0d count %0d %s",
						         got.status, got.entry_count,
						         $sformatf("third %h valid %b",
						                   got.third_from_end, got.third_valid));
				end else begin
					want = pending_rsp.pop_front();
					if (got.status !== want.status ||
					    got.entry_count !== want.entry_count ||
					    got.third_from_end !== want.third_from_end ||
					    got.third_valid !== want.third_valid) begin
						mismatch_cnt++;
						if (mismatch_cnt <= SHOW_MAX)
							$display("result mismatch: exp st %0d cnt %0d third %h v %b, %s",
							         want.status, want.entry_count,
							         want.third_from_end, want.third_valid,
							         $sformatf("got st %0d cnt %0d third %h v %b",
							                   got.status, got.entry_count,
							                   got.third_from_end, got.third_valid));
					end
				end
			end
			if (start && !busy) begin
				want = set_update(cmd);
				pending_rsp.push_back(cur_typed ? cur_rsp : want);
			end
			if (stall_cycles >= STALL_MAX) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		sst_pkg::rsp_word_t         blank;
		logic [sst_pkg::MODE_W-1:0] m;
		logic [sst_pkg::VAL_W-1:0]  v;
		int                         pick;
		bit                         fill_phase;

		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cur_typed    = 1'b0;
		cur_rsp      = '0;
		blank        = '0;
		held_cnt     = 0;
		mismatch_cnt = 0;
		stall_cycles = 0;

		// read straight off an empty set and a three-value set
		add_row(MODE_QRY,         '0,      1, sst_pkg::ST_NOTFOUND, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, VAL_MAX, 1, sst_pkg::ST_ABSENT,   0, '0, 1'b0);
		add_row(sst_pkg::MODE_ADD, '0,      1, sst_pkg::ST_ADDED,    1, '0, 1'b0);
		add_row(sst_pkg::MODE_ADD, '0,      1, sst_pkg::ST_PRESENT,  1, '0, 1'b0);
		add_row(sst_pkg::MODE_ADD, VAL_MAX, 1, sst_pkg::ST_ADDED,    2, '0, 1'b0);
		add_row(sst_pkg::MODE_ADD, 31'd5,   1, sst_pkg::ST_ADDED,    3, '0, 1'b1);
		add_row(MODE_QRY3,         31'd5,   1, sst_pkg::ST_FOUND,    3, '0, 1'b1);
		add_row(MODE_QRY,          31'd6,   1, sst_pkg::ST_NOTFOUND, 3, '0, 1'b1);
		// remainder checked by the model
		add_row(sst_pkg::MODE_ADD, 31'h5555_5555, 0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_ADD, 31'h2AAA_AAAA, 0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, '0,            0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, '0,            0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(MODE_QRY3,         VAL_MAX,       0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, VAL_MAX,       0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(MODE_QRY3,         VAL_MAX,       0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, 31'h2AAA_AAAA, 0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(MODE_QRY,          31'd5,         0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, 31'd5,         0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, 31'h5555_5555, 0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, 31'd1,         0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_ADD, 31'd1,         0, sst_pkg::ST_ADDED, 0, '0, 1'b0);
		add_row(sst_pkg::MODE_DEL, 31'd1,         0, sst_pkg::ST_ADDED, 0, '0, 1'b0);

		// small values collide often; wide ones exercise every bit
		val_pool[0] = '0;
		val_pool[1] = VAL_MAX;
		for (int i = 2; i < POOL_N; i++)
			val_pool[i] = (i < 40) ? sst_pkg::VAL_W'($urandom_range(0, 200))
			                       : sst_pkg::VAL_W'($urandom());

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed,
			          dir_rows[i].rsp, 1'b1);

		// alternate fill-heavy and drain-heavy stretches so the table both
		// fills up and empties again
		for (int i = 0; i < RAND_ITEMS; i++) begin
			fill_phase = ((i / 170) % 2) == 0;
			pick = $urandom_range(99);
			if (pick < (fill_phase ? 70 : 15))
				m = sst_pkg::MODE_ADD;
			else if (pick < (fill_phase ? 85 : 80))
				m = sst_pkg::MODE_DEL;
			else
				m = $urandom_range(1) ? MODE_QRY3 : MODE_QRY;
			if ($urandom_range(99) < 10)
				v = sst_pkg::VAL_W'($urandom());
			else
				v = val_pool[$urandom_range(POOL_N - 1)];
			send_word(m, v, 1'b0, blank, !(i >= 700 && i < 1000));
		end
		start <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
